// ===== rtl/owbm_pkg.sv =====
package owbm_pkg;

  // Field widths
  localparam int unsigned ModeW    = 3;
  localparam int unsigned TimerW   = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SerialW  = 48;
  localparam int unsigned SerialN  = SerialW / ByteW;
  localparam int unsigned ByteIdxW = 4;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Stream payload widths (bytes filled with zeros)
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 80;

  // Command codes carried in the input tuser
  localparam logic [ModeW-1:0] MODE_TICK  = 3'd0;
  localparam logic [ModeW-1:0] MODE_RESET = 3'd1;
  localparam logic [ModeW-1:0] MODE_WRITE = 3'd2;
  localparam logic [ModeW-1:0] MODE_READ  = 3'd3;
  localparam logic [ModeW-1:0] MODE_ROM   = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRES_SAMPLE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOT        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_LOW   = 3'd4;

  // Configuration reset values
  localparam logic [9:0] RESET_LOW_DEF   = 10'd485;
  localparam logic [7:0] PRES_SAMPLE_DEF = 8'd30;
  localparam logic [7:0] SLOT_DEF        = 8'd60;
  localparam logic [7:0] READ_SAMPLE_DEF = 8'd10;
  localparam logic [3:0] START_LOW_DEF   = 4'd1;

  // Read ROM byte sequence
  localparam logic [ByteW-1:0]    ROM_READ_CODE   = 8'h33;
  localparam logic [ByteIdxW-1:0] ROM_BYTE_CMD    = 4'd0;
  localparam logic [ByteIdxW-1:0] ROM_BYTE_FAMILY = 4'd1;
  localparam logic [ByteIdxW-1:0] ROM_BYTE_SERIAL = 4'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_SLOT_START,
    PH_SLOT_BODY
  } phase_e;

  typedef struct packed {
    logic [9:0]        reset_low;
    logic [7:0]        pres_sample;
    logic [7:0]        slot;
    logic [3:0]        start_low;
    logic [TimerW-1:0] rec_dur;    // recovery after the presence sample
    logic [7:0]        sample_at;  // read sample point inside a slot
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]   rom_crc;
    logic [SerialW-1:0] serial_number;
    logic [ByteW-1:0]   family_byte;
    logic [ByteW-1:0]   rx_byte;
    logic               presence;
    logic               done_res;
    logic               busy_res;
    logic               drive_low;
  } res_t;

endpackage

// ===== rtl/one_wire_bus_master_unit.sv =====
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tuser: mode; tdata: tx_byte, line_level
// m_axis    out  tvalid/tready           tdata: drive_low .. rom_crc (one per input)
// cfg       in   cfg_we_i (no wait)      cfg_idx_i selects, cfg_wdata_i data
//
// Every input transfer is one microsecond tick; its result is registered and shown in the cycle after it.
// The next-state logic runs in the cycle of the input transfer, and a single result
// register holds the answer, so one transfer per clock is sustained while m_axis_tready is high.
// s_axis_tready drops only while the result register is full and m_axis_tready is low.
// Reset (rst_ni low, asynchronous) returns to idle with the default timings loaded.
module one_wire_bus_master_unit
  import owbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] tx_byte, [8] line_level
  input  logic [ModeW-1:0]    s_axis_tuser,   // [2:0] mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                              // [3] presence, [11:4] rx_byte,
                                              // [19:12] family byte, [67:20] serial_number,
                                              // [75:68] rom_crc
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic in_xfer;

  // Take a new item whenever the result register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  owbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  owbm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_xfer),
    .mode_i       (s_axis_tuser),
    .tx_byte_i    (s_axis_tdata[ByteW-1:0]),
    .line_level_i (s_axis_tdata[ByteW]),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Result register: load on input transfer, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, res_q};

endmodule

// ===== rtl/owbm_cfg.sv =====
module owbm_cfg
  import owbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output cfg_t                cfg_o
);

  logic [9:0] reset_low_q;
  logic [7:0] pres_sample_q;
  logic [7:0] slot_q;
  logic [7:0] read_sample_q;
  logic [3:0] start_low_q;
  logic [7:0] sample_min;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q   <= RESET_LOW_DEF;
      pres_sample_q <= PRES_SAMPLE_DEF;
      slot_q        <= SLOT_DEF;
      read_sample_q <= READ_SAMPLE_DEF;
      start_low_q   <= START_LOW_DEF;
    end else if (we_i) begin
      unique case (idx_i)
        CFG_RESET_LOW:   reset_low_q   <= wdata_i[9:0];
        CFG_PRES_SAMPLE: pres_sample_q <= wdata_i[7:0];
        CFG_SLOT:        slot_q        <= wdata_i[7:0];
        CFG_READ_SAMPLE: read_sample_q <= wdata_i[7:0];
        CFG_START_LOW:   start_low_q   <= wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the read sample into the slot, and never earlier than one tick
  assign sample_min = (read_sample_q < slot_q) ? read_sample_q : slot_q;

  always_comb begin
    cfg_o.reset_low   = reset_low_q;
    cfg_o.pres_sample = pres_sample_q;
    cfg_o.slot        = slot_q;
    cfg_o.start_low   = start_low_q;
    cfg_o.rec_dur     = (reset_low_q > {2'b00, pres_sample_q}) ?
                        (reset_low_q - {2'b00, pres_sample_q}) : '0;
    cfg_o.sample_at   = (sample_min == 8'd0) ? 8'd1 : sample_min;
  end

endmodule

// ===== rtl/owbm_ctrl.sv =====
module owbm_ctrl
  import owbm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ModeW-1:0] mode_i,
  input  logic [ByteW-1:0] tx_byte_i,
  input  logic             line_level_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  phase_e              phase_q, phase_d;
  logic [TimerW-1:0]   timer_q, timer_d;
  logic [BitIdxW-1:0]  bit_idx_q, bit_idx_d;
  logic [ByteIdxW-1:0] byte_idx_q, byte_idx_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic                pres_q, pres_d;
  logic [ByteW-1:0]    family_q, family_d;
  logic [SerialW-1:0]  serial_q, serial_d;
  logic [ByteW-1:0]    crc_q, crc_d;
  logic [ModeW-1:0]    kind_q, kind_d;
  logic [ByteW-1:0]    rx_q, rx_d;

  logic [TimerW-1:0]  timer_inc;
  logic [BitIdxW-1:0] bit_next;
  logic [ByteW-1:0]   shift_s;
  logic               writing_q, writing_d;
  logic               done;

  assign timer_inc = timer_q + 1'b1;
  assign bit_next  = bit_idx_q + 1'b1;
  assign writing_q = (kind_q == MODE_WRITE) ||
                     ((kind_q == MODE_ROM) && (byte_idx_q == ROM_BYTE_CMD));

  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_q;
    bit_idx_d  = bit_idx_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    pres_d     = pres_q;
    family_d   = family_q;
    serial_d   = serial_q;
    crc_d      = crc_q;
    kind_d     = kind_q;
    rx_d       = rx_q;
    done       = 1'b0;
    shift_s    = shift_q;

    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        unique case (mode_i)
          MODE_RESET, MODE_ROM: begin
            kind_d  = mode_i;
            phase_d = PH_RST_LOW;
            timer_d = '0;
          end
          MODE_WRITE: begin
            kind_d    = mode_i;
            shift_d   = tx_byte_i;
            bit_idx_d = '0;
            phase_d   = PH_SLOT_START;
            timer_d   = '0;
          end
          MODE_READ: begin
            kind_d    = mode_i;
            shift_d   = '0;
            bit_idx_d = '0;
            phase_d   = PH_SLOT_START;
            timer_d   = '0;
          end
          default: ;
        endcase
      end else begin
        timer_d = timer_inc;
        unique case (phase_q)
          PH_RST_LOW: begin
            if (timer_inc >= cfg_i.reset_low) begin
              phase_d = PH_RST_WAIT;
              timer_d = '0;
            end
          end
          PH_RST_WAIT: begin
            if (timer_inc >= {2'b00, cfg_i.pres_sample}) begin
              pres_d  = !line_level_i;
              phase_d = PH_RST_REC;
              timer_d = '0;
            end
          end
          PH_RST_REC: begin
            if (timer_inc >= cfg_i.rec_dur) begin
              if ((kind_q == MODE_ROM) && pres_q) begin
                byte_idx_d = ROM_BYTE_CMD;
                shift_d    = ROM_READ_CODE;
                bit_idx_d  = '0;
                phase_d    = PH_SLOT_START;
                timer_d    = '0;
              end else begin
                phase_d = PH_IDLE;
                timer_d = '0;
                done    = 1'b1;
              end
            end
          end
          PH_SLOT_START: begin
            if (timer_inc >= {6'd0, cfg_i.start_low}) begin
              phase_d = PH_SLOT_BODY;
              timer_d = '0;
            end
          end
          PH_SLOT_BODY: begin
            // Sample a read bit into the top, LSB first
            if (!writing_q && (timer_inc == {2'b00, cfg_i.sample_at})) begin
              shift_s = {line_level_i, shift_q[ByteW-1:1]};
            end
            if (timer_inc >= {2'b00, cfg_i.slot}) begin
              if (writing_q) begin
                shift_s = {1'b0, shift_s[ByteW-1:1]};
              end
              bit_idx_d = bit_next;
              shift_d   = shift_s;
              phase_d   = PH_SLOT_START;
              timer_d   = '0;
              if (bit_next == '0) begin
                // Byte complete
                if (kind_q == MODE_ROM) begin
                  shift_d = '0;
                  if (byte_idx_q != ROM_BYTE_CMD) begin
                    rx_d = shift_s;
                  end
                  if (byte_idx_q == ROM_BYTE_CMD) begin
                    byte_idx_d = ROM_BYTE_FAMILY;
                  end else if (byte_idx_q == ROM_BYTE_FAMILY) begin
                    family_d   = shift_s;
                    byte_idx_d = byte_idx_q + 1'b1;
                  end else if (byte_idx_q < ROM_BYTE_SERIAL + ByteIdxW'(SerialN)) begin
                    for (int k = 0; k < SerialN; k++) begin
                      if (byte_idx_q == ROM_BYTE_SERIAL + ByteIdxW'(k)) begin
                        serial_d[k*ByteW +: ByteW] = shift_s;
                      end
                    end
                    byte_idx_d = byte_idx_q + 1'b1;
                  end else begin
                    crc_d   = shift_s;
                    shift_d = shift_s;
                    phase_d = PH_IDLE;
                    done    = 1'b1;
                  end
                end else begin
                  if (kind_q == MODE_READ) begin
                    rx_d = shift_s;
                  end
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
              end
            end else begin
              shift_d = shift_s;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      timer_q    <= '0;
      bit_idx_q  <= '0;
      byte_idx_q <= '0;
      shift_q    <= '0;
      pres_q     <= 1'b0;
      family_q   <= '0;
      serial_q   <= '0;
      crc_q      <= '0;
      kind_q     <= MODE_TICK;
      rx_q       <= '0;
    end else begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      bit_idx_q  <= bit_idx_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      pres_q     <= pres_d;
      family_q   <= family_d;
      serial_q   <= serial_d;
      crc_q      <= crc_d;
      kind_q     <= kind_d;
      rx_q       <= rx_d;
    end
  end

  // Result reflects the state after this step
  assign writing_d = (kind_d == MODE_WRITE) ||
                     ((kind_d == MODE_ROM) && (byte_idx_d == ROM_BYTE_CMD));

  always_comb begin
    res_o.drive_low     = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_START) ||
                          ((phase_d == PH_SLOT_BODY) && writing_d && !shift_d[0]);
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.done_res      = done;
    res_o.presence      = pres_d;
    res_o.rx_byte       = rx_d;
    res_o.family_byte   = family_d;
    res_o.serial_number = serial_d;
    res_o.rom_crc       = crc_d;
  end

endmodule

// ===== rtl/owbm_checker.sv =====
module owbm_checker
  import owbm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // No result shows while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Empty result register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // A finishing command leaves the master idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("done and busy together");

  // Bus is pulled low only while a command runs
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("bus driven low while idle");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
